// ----- src/gpfd_pkg.sv -----
// Shared constants, types and field widths for the gamepad poll frame decoder.
package gpfd_pkg;

    // Frame header codes
    localparam logic [7:0] ACK_OK        = 8'h5A;
    localparam logic [7:0] MODE_DIGITAL  = 8'h41;
    localparam logic [7:0] MODE_ANALOG_A = 8'h73;
    localparam logic [7:0] MODE_ANALOG_B = 8'h79;

    // Safe-state and reset values
    localparam logic [15:0] SAFE_BUTTONS = 16'hFFFF;
    localparam logic [7:0]  LIMIT_RESET  = 8'd20;

    // Counter width default and the fixed width of the counter fields on the port
    localparam int COUNT_WIDTH_DEF = 32;
    localparam int COUNT_PORT_W    = 32;

    // Stream widths
    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 160;

    // Stick values after conversion
    typedef struct packed {
        logic signed [7:0] right_x;
        logic signed [8:0] right_y;
        logic signed [7:0] left_x;
        logic signed [8:0] left_y;
    } t_sticks;

    // Decoded view of one frame
    typedef struct packed {
        logic        valid;
        logic        analog;
        logic [7:0]  mode;
        logic [15:0] buttons;
        t_sticks     sticks;
    } t_frame_info;

endpackage

// ----- src/gpfd_decode.sv -----
// Header check and stick conversion for one poll response frame.
module gpfd_decode
    import gpfd_pkg::*;
(
    input  logic [IN_TDATA_W-1:0] i_frame,
    output t_frame_info           o_info
);

    logic [7:0] w_mode;
    logic [7:0] w_ack;
    logic       w_analog;

    assign w_mode   = i_frame[7:0];
    assign w_ack    = i_frame[15:8];
    assign w_analog = (w_mode == MODE_ANALOG_A) || (w_mode == MODE_ANALOG_B);

    // raw - 128 in eight bits; the value just below center reads as zero
    function automatic logic signed [7:0] conv_x(input logic [7:0] raw);
        logic [7:0] v;
        v = {~raw[7], raw[6:0]};
        return (v == 8'hFF) ? 8'sd0 : $signed(v);
    endfunction

    // 128 - raw in nine bits
    function automatic logic signed [8:0] conv_y(input logic [7:0] raw);
        return $signed(9'd128 - {1'b0, raw});
    endfunction

    always_comb begin
        o_info.valid          = (w_ack == ACK_OK) && (w_analog || (w_mode == MODE_DIGITAL));
        o_info.analog         = w_analog;
        o_info.mode           = w_mode;
        o_info.buttons        = {i_frame[31:24], i_frame[23:16]};
        o_info.sticks.right_x = conv_x(i_frame[39:32]);
        o_info.sticks.right_y = conv_y(i_frame[47:40]);
        o_info.sticks.left_x  = conv_x(i_frame[55:48]);
        o_info.sticks.left_y  = conv_y(i_frame[63:56]);
    end

endmodule

// ----- src/gpfd_tracker.sv -----
// Link state, latched values and frame counters, updated once per decoded frame.
module gpfd_tracker
    import gpfd_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_update,
    input  t_frame_info            i_info,
    input  logic [7:0]             i_lost_limit,
    output logic                   o_connected,
    output logic                   o_frame_ok,
    output logic                   o_analog_ok,
    output logic [7:0]             o_mode_id,
    output logic [15:0]            o_buttons,
    output t_sticks                o_sticks,
    output logic [COUNT_WIDTH-1:0] o_good,
    output logic [COUNT_WIDTH-1:0] o_bad,
    output logic [COUNT_WIDTH-1:0] o_lost
);

    logic                   r_present, n_present;
    logic                   r_frame_ok, n_frame_ok;
    logic                   r_analog, n_analog;
    logic [7:0]             r_mode, n_mode;
    logic [15:0]            r_buttons, n_buttons;
    t_sticks                r_sticks, n_sticks;
    logic [COUNT_WIDTH-1:0] r_good, n_good;
    logic [COUNT_WIDTH-1:0] r_bad, n_bad;
    logic [COUNT_WIDTH-1:0] r_lost, n_lost;
    logic [COUNT_WIDTH-1:0] w_lost_inc;
    logic [COUNT_WIDTH-1:0] w_limit;

    assign w_lost_inc = r_lost + COUNT_WIDTH'(1);
    assign w_limit    = COUNT_WIDTH'(i_lost_limit);

    // Work out the state after this frame
    always_comb begin
        n_present  = r_present;
        n_frame_ok = r_frame_ok;
        n_analog   = r_analog;
        n_mode     = r_mode;
        n_buttons  = r_buttons;
        n_sticks   = r_sticks;
        n_good     = r_good;
        n_bad      = r_bad;
        n_lost     = r_lost;
        if (i_info.valid) begin
            n_present  = 1'b1;
            n_frame_ok = 1'b1;
            n_mode     = i_info.mode;
            n_buttons  = i_info.buttons;
            n_good     = r_good + COUNT_WIDTH'(1);
            n_lost     = '0;
            n_analog   = i_info.analog;
            if (i_info.analog) begin
                n_sticks = i_info.sticks;
            end
        end else begin
            n_frame_ok = 1'b0;
            n_bad      = r_bad + COUNT_WIDTH'(1);
            n_lost     = w_lost_inc;
            // Drop to safe values once the bad run passes the limit
            if (w_lost_inc > w_limit) begin
                n_present = 1'b0;
                n_analog  = 1'b0;
                n_mode    = '0;
                n_buttons = SAFE_BUTTONS;
                n_sticks  = '0;
            end
        end
    end

    // Advance state on each decoded frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present  <= 1'b0;
            r_frame_ok <= 1'b0;
            r_analog   <= 1'b0;
            r_mode     <= '0;
            r_buttons  <= SAFE_BUTTONS;
            r_sticks   <= '0;
            r_good     <= '0;
            r_bad      <= '0;
            r_lost     <= '0;
        end else if (i_update) begin
            r_present  <= n_present;
            r_frame_ok <= n_frame_ok;
            r_analog   <= n_analog;
            r_mode     <= n_mode;
            r_buttons  <= n_buttons;
            r_sticks   <= n_sticks;
            r_good     <= n_good;
            r_bad      <= n_bad;
            r_lost     <= n_lost;
        end
    end

    assign o_connected = r_present;
    assign o_frame_ok  = r_frame_ok;
    assign o_analog_ok = r_analog;
    assign o_mode_id   = r_mode;
    assign o_buttons   = r_buttons;
    assign o_sticks    = r_sticks;
    assign o_good      = r_good;
    assign o_bad       = r_bad;
    assign o_lost      = r_lost;

endmodule

// ----- src/gamepad_poll_frame_decoder_top.sv -----
// Top level of the gamepad poll frame decoder: input stage, config register, result beat.
//
// Usage:
//   s_axis carries one poll response frame per beat (mode, ack, two button bytes,
//   four stick bytes). m_axis carries one result per frame: the link state, latched
//   mode and buttons, converted sticks and the good/bad/lost counters after that frame.
//   The cfg channel writes lost_limit (8 bits); write it only while no frame is in
//   flight. o_cfg_ready is always high.
// Path: input register, decoder, then tracker registers that hold the result beat.
// Throughput: one frame per cycle; the input register feeds the decoder and the
//   tracker state registers double as the result register, so both advance together
//   whenever the result beat is empty or being taken.
// Reset (synchronous, active low): safe state (disconnected, mode 0, buttons 0xFFFF,
//   sticks 0), counters 0, lost_limit 20, no beat pending.
// Stall: while m_axis_tready is low a pending result holds; one more frame can sit in
//   the input register, then s_axis_tready drops until the result is taken.
// Counters are COUNT_WIDTH bits, wrap, and are zero-extended to 32 bits on the port.
module gamepad_poll_frame_decoder_top
    import gpfd_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // mode_byte, ack_byte, buttons_low, buttons_high,
    // right_x_raw, right_y_raw, left_x_raw, left_y_raw
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // connected, frame_ok, analog_ok, mode_id, buttons, right_x, right_y,
    // left_x, left_y, good_frames, bad_frames, lost_run, zero pad to 160
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [7:0]             i_cfg_data
);

    logic [IN_TDATA_W-1:0]  r_in_data;
    logic                   r_in_valid;
    logic                   r_out_valid;
    logic [7:0]             r_lost_limit;
    logic                   w_advance;
    t_frame_info            w_info;
    logic                   w_connected;
    logic                   w_frame_ok;
    logic                   w_analog_ok;
    logic [7:0]             w_mode_id;
    logic [15:0]            w_buttons;
    t_sticks                w_sticks;
    logic [COUNT_WIDTH-1:0] w_good;
    logic [COUNT_WIDTH-1:0] w_bad;
    logic [COUNT_WIDTH-1:0] w_lost;

    // Move a frame into the tracker when the result slot is free or being taken
    assign w_advance     = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_advance;
    assign o_cfg_ready   = 1'b1;

    // Hold the config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lost_limit <= LIMIT_RESET;
        end else if (i_cfg_valid) begin
            r_lost_limit <= i_cfg_data;
        end
    end

    // Input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_data <= s_axis_tdata;
        end
    end

    // Result beat valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    gpfd_decode u_decode (
        .i_frame (r_in_data),
        .o_info  (w_info)
    );

    gpfd_tracker #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_tracker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_update     (w_advance),
        .i_info       (w_info),
        .i_lost_limit (r_lost_limit),
        .o_connected  (w_connected),
        .o_frame_ok   (w_frame_ok),
        .o_analog_ok  (w_analog_ok),
        .o_mode_id    (w_mode_id),
        .o_buttons    (w_buttons),
        .o_sticks     (w_sticks),
        .o_good       (w_good),
        .o_bad        (w_bad),
        .o_lost       (w_lost)
    );

    // Pack the result beat
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {
        3'b000,
        COUNT_PORT_W'(w_lost),
        COUNT_PORT_W'(w_bad),
        COUNT_PORT_W'(w_good),
        w_sticks.left_y,
        w_sticks.left_x,
        w_sticks.right_y,
        w_sticks.right_x,
        w_buttons,
        w_mode_id,
        w_analog_ok,
        w_frame_ok,
        w_connected
    };

endmodule
